>>> sv/txc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the text-mode console writer.
// No dependencies; used by text_mode_console_writer.
package txc_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 8;
  localparam int TAB_SHIFT  = $clog2(TAB_STOP);
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int IDX_W   = 11;
  localparam int OFF_W   = 11;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 4;
  localparam int ATTR_W  = 2 * COLOR_W;

  // Widened cursor values before wrap and scroll
  localparam int COL_X_W = COL_W + 1;
  localparam int ROW_X_W = ROW_W + 1;

  // Stream packing
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'd1;

  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;
  localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Blank cell after reset
  localparam logic [CELL_W-1:0] BLANK_RESET = {BG_RESET, FG_RESET, CH_SPACE};

  // Command codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_MOVE  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  // Linear cell offset of a cursor position
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col));
  endfunction

endpackage

>>> sv/txc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module txc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/text_mode_console_writer.sv
`timescale 1ns / 1ps
// Throughput: one command at a time; the next is taken after the result transaction.
//   Scroll and clear walk the cell RAM through its single write port; clear writes one cell per cycle.
// Reset: asynchronous, active low; afterwards an init pass blanks every cell to 0x0F20
//   and no command is taken meanwhile. Configuration writes are taken at any time.
// Depends on txc_pkg and txc_ram.
module text_mode_console_writer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Command stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [7:0] char_code, [14:8] target_column, [19:15] target_row, [30:20] cell_index
  input  logic [txc_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // [1:0] func
  input  logic [txc_pkg::FUNC_W-1:0]        s_axis_tuser_i,
  // Result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [6:0] cursor_column, [11:7] cursor_row, [22:12] cursor_offset, [38:23] cell_word
  output logic [txc_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // Configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [txc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [txc_pkg::COLOR_W-1:0]       cfg_data_i
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_RESP
  } state_e;

  localparam logic [txc_pkg::ADDR_W-1:0] LAST_CELL =
    txc_pkg::ADDR_W'(txc_pkg::CELL_COUNT - 1);
  localparam logic [txc_pkg::ADDR_W-1:0] SCROLL_LAST =
    txc_pkg::ADDR_W'((txc_pkg::ROWS - 1) * txc_pkg::COLUMNS - 1);

  state_e                          state_q;
  logic [txc_pkg::ADDR_W-1:0]      ptr_q;
  logic [txc_pkg::COL_W-1:0]       col_q;
  logic [txc_pkg::ROW_W-1:0]       row_q;
  logic [txc_pkg::COLOR_W-1:0]     bg_q;
  logic [txc_pkg::COLOR_W-1:0]     fg_q;
  logic [txc_pkg::CELL_W-1:0]      cell_q;
  logic [txc_pkg::CELL_W-1:0]      fill_q;

  // Input fields
  txc_pkg::func_e                  func;
  logic [txc_pkg::CHAR_W-1:0]      char_code;
  logic [txc_pkg::COL_W-1:0]       target_column;
  logic [txc_pkg::ROW_W-1:0]       target_row;
  logic [txc_pkg::IDX_W-1:0]       cell_index;

  logic                            in_accept;
  logic [txc_pkg::ATTR_W-1:0]      attr;
  logic [txc_pkg::CELL_W-1:0]      blank;
  logic [txc_pkg::COL_X_W-1:0]     col_x;
  logic [txc_pkg::ROW_X_W-1:0]     row_x;
  logic                            put_we;
  logic                            scroll;

  logic                            ram_we;
  logic [txc_pkg::ADDR_W-1:0]      ram_waddr;
  logic [txc_pkg::CELL_W-1:0]      ram_wdata;
  logic [txc_pkg::ADDR_W-1:0]      ram_raddr;
  logic [txc_pkg::CELL_W-1:0]      ram_rdata;

  assign func          = txc_pkg::func_e'(s_axis_tuser_i);
  assign char_code     = s_axis_tdata_i[7:0];
  assign target_column = s_axis_tdata_i[14:8];
  assign target_row    = s_axis_tdata_i[19:15];
  assign cell_index    = s_axis_tdata_i[30:20];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign attr            = {bg_q, fg_q};
  assign blank           = {attr, txc_pkg::CH_SPACE};

  // Result word
  assign m_axis_tvalid_o = (state_q == ST_RESP);
  assign m_axis_tdata_o  = {1'b0, cell_q,
                            txc_pkg::OFF_W'(txc_pkg::cell_addr(row_q, col_q)),
                            row_q, col_q};

  // Next cursor for put char and move cursor, then column wrap
  always_comb begin
    col_x  = {1'b0, col_q};
    row_x  = {1'b0, row_q};
    put_we = 1'b0;
    case (func)
      txc_pkg::FUNC_PUT: begin
        if (char_code == txc_pkg::CH_BS) begin
          if (col_q != '0) col_x = col_x - 1'b1;
        end else if (char_code == txc_pkg::CH_TAB) begin
          col_x = ((col_x >> txc_pkg::TAB_SHIFT) + 1'b1) << txc_pkg::TAB_SHIFT;
        end else if (char_code == txc_pkg::CH_LF) begin
          col_x = '0;
          row_x = row_x + 1'b1;
        end else if (char_code == txc_pkg::CH_CR) begin
          col_x = '0;
        end else if (char_code >= txc_pkg::CH_SPACE) begin
          put_we = 1'b1;
          col_x  = col_x + 1'b1;
        end
      end
      txc_pkg::FUNC_MOVE: begin
        col_x = {1'b0, target_column};
        row_x = {1'b0, target_row};
      end
      default: ;
    endcase
    if (col_x >= txc_pkg::COL_X_W'(txc_pkg::COLUMNS)) begin
      col_x = '0;
      row_x = row_x + 1'b1;
    end
  end

  assign scroll = (row_x >= txc_pkg::ROW_X_W'(txc_pkg::ROWS));

  // RAM port control per sequencer step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = fill_q;
    ram_raddr = ptr_q;
    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = txc_pkg::BLANK_RESET;
      end
      ST_IDLE: begin
        ram_we    = in_accept && (func == txc_pkg::FUNC_PUT) && put_we;
        ram_waddr = txc_pkg::cell_addr(row_q, col_q);
        ram_wdata = {attr, char_code};
        ram_raddr = txc_pkg::ADDR_W'(cell_index);
      end
      ST_SCR_RD: begin
        ram_raddr = ptr_q + txc_pkg::ADDR_W'(txc_pkg::COLUMNS);
      end
      ST_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      ST_FILL: begin
        ram_we = 1'b1;
      end
      ST_READ, ST_RESP: ;
      default: ;
    endcase
  end

  txc_ram #(
    .WIDTH (txc_pkg::CELL_W),
    .DEPTH (txc_pkg::CELL_COUNT)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer, cursor and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      ptr_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      bg_q    <= txc_pkg::BG_RESET;
      fg_q    <= txc_pkg::FG_RESET;
      cell_q  <= '0;
      fill_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          txc_pkg::CFG_BACKGROUND: bg_q <= cfg_data_i;
          txc_pkg::CFG_FOREGROUND: fg_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        ST_INIT: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == LAST_CELL) begin
            ptr_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            cell_q <= '0;
            ptr_q  <= '0;
            case (func) inside
              txc_pkg::FUNC_PUT, txc_pkg::FUNC_MOVE: begin
                col_q <= col_x[txc_pkg::COL_W-1:0];
                if (scroll) begin
                  row_q   <= txc_pkg::ROW_W'(txc_pkg::ROWS - 1);
                  state_q <= ST_SCR_RD;
                end else begin
                  row_q   <= row_x[txc_pkg::ROW_W-1:0];
                  state_q <= ST_RESP;
                end
              end
              txc_pkg::FUNC_CLEAR: begin
                fill_q  <= blank;
                state_q <= ST_FILL;
              end
              default: begin
                if (cell_index < txc_pkg::IDX_W'(txc_pkg::CELL_COUNT)) begin
                  state_q <= ST_READ;
                end else begin
                  state_q <= ST_RESP;
                end
              end
            endcase
          end
        end
        ST_READ: begin
          cell_q  <= ram_rdata;
          state_q <= ST_RESP;
        end
        ST_SCR_RD: begin
          state_q <= ST_SCR_WR;
        end
        ST_SCR_WR: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == SCROLL_LAST) begin
            fill_q  <= blank;
            state_q <= ST_FILL;
          end else begin
            state_q <= ST_SCR_RD;
          end
        end
        ST_FILL: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == LAST_CELL) begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (m_axis_tready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Cursor stays on screen whenever a result is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (row_q < txc_pkg::ROW_W'(txc_pkg::ROWS)) &&
                        (col_q < txc_pkg::COL_W'(txc_pkg::COLUMNS)))
    else $error("cursor off screen at result");

  // Every RAM write lands inside the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr <= LAST_CELL))
    else $error("cell write beyond screen");

  // Scroll copy never writes into the last row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCR_WR) |-> (ptr_q <= SCROLL_LAST))
    else $error("scroll copy past last row boundary");

  // An accepted command blocks the input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready_o)
    else $error("input taken twice in a row");

  // A result never coincides with input readiness
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid_o && s_axis_tready_o))
    else $error("result pending while input ready");

endmodule
